// ----- hw/rtl/adjacent_swap_permutation_guide_unit_assert.svh -----
// Assertion macros used by the guide unit's top-level RTL file.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ADJACENT_SWAP_PERMUTATION_GUIDE_UNIT_ASSERT_SVH
`define ADJACENT_SWAP_PERMUTATION_GUIDE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASPG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASPG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/aspg_pkg.sv -----
package aspg_pkg;

	// Fixed field widths of the stream and configuration ports.
	localparam int unsigned TDATA_W = 8;
	localparam int unsigned POS_W = 3;
	localparam int unsigned SIZE_W = 4;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd6;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DONE
	} state_t;

	// Status seen by the sequencer.
	typedef struct packed {
		logic accept;
		logic tick;
		logic move_ok;
		logic sweep_end;
		logic out_free;
	} ctrl_status_t;

	// Commands issued by the sequencer.
	typedef struct packed {
		logic ready;
		logic start;
		logic wrap;
		logic step;
		logic load_out;
	} ctrl_cmd_t;

	// Flags produced by the shared step unit.
	typedef struct packed {
		logic swap_now;
		logic mobile;
		logic better;
	} step_flag_t;

endpackage

// ----- hw/rtl/aspg_step_unit.sv -----
module aspg_step_unit #(
	parameter int unsigned MAX_ELEMENTS = 8
) (
	input  logic [$clog2(MAX_ELEMENTS)-1:0]   pos,
	input  logic [$clog2(MAX_ELEMENTS+1)-1:0] n,
	input  logic [$clog2(MAX_ELEMENTS)-1:0]   low,
	input  logic [$clog2(MAX_ELEMENTS)-1:0]   moved_elem,
	input  logic [$clog2(MAX_ELEMENTS)-1:0]   tap0_elem,
	input  logic                              tap0_dir,
	input  logic [$clog2(MAX_ELEMENTS)-1:0]   tap1_elem,
	input  logic                              tap1_dir,
	input  logic [$clog2(MAX_ELEMENTS)-1:0]   tap2_elem,
	input  logic [$clog2(MAX_ELEMENTS)-1:0]   prev_elem,
	input  logic                              mob_valid,
	input  logic [$clog2(MAX_ELEMENTS)-1:0]   mob_elem,
	output logic [$clog2(MAX_ELEMENTS)-1:0]   proc_elem,
	output logic                              proc_dir,
	output aspg_pkg::step_flag_t              flags
);
	import aspg_pkg::*;

	localparam int unsigned EW = $clog2(MAX_ELEMENTS);
	localparam int unsigned NW = $clog2(MAX_ELEMENTS + 1);

	logic          swap_now;
	logic          pre_swap;
	logic          has_right;
	logic [EW-1:0] cur_elem;
	logic          cur_dir;
	logic [EW-1:0] right_elem;
	logic          mobile;

	// The position being processed takes the neighbor's entry when it is the swap point.
	assign swap_now = (pos == low);
	assign pre_swap = ((NW'(pos) + NW'(1)) == NW'(low));
	assign has_right = ((NW'(pos) + NW'(1)) < n);
	assign cur_elem = swap_now ? tap1_elem : tap0_elem;
	assign cur_dir = swap_now ? tap1_dir : tap0_dir;

	// Every element larger than the moved one turns around.
	assign proc_elem = cur_elem;
	assign proc_dir = cur_dir ^ (cur_elem > moved_elem);

	// The right neighbor as it stands after the swap.
	always_comb begin
		if (swap_now) begin
			right_elem = tap0_elem;
		end else if (pre_swap) begin
			right_elem = tap2_elem;
		end else begin
			right_elem = tap1_elem;
		end
	end

	// An element is mobile when it faces a smaller neighbor.
	assign mobile = (!proc_dir && (pos != '0) && (cur_elem > prev_elem)) ||
		(proc_dir && has_right && (cur_elem > right_elem));

	assign flags.swap_now = swap_now;
	assign flags.mobile = mobile;
	assign flags.better = mobile && (!mob_valid || (cur_elem > mob_elem));

endmodule

// ----- hw/rtl/aspg_ctrl.sv -----
module aspg_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  aspg_pkg::ctrl_status_t status,
	output aspg_pkg::ctrl_cmd_t    cmd
);
	import aspg_pkg::*;

	state_t state_q;
	state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands.
	always_comb begin
		state_next = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (status.accept && status.tick) begin
					if (status.move_ok) begin
						cmd.start = 1'b1;
						state_next = ST_SWEEP;
					end else begin
						cmd.wrap = 1'b1;
						state_next = ST_DONE;
					end
				end
			end
			ST_SWEEP: begin
				cmd.step = 1'b1;
				if (status.sweep_end) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/adjacent_swap_permutation_guide_unit.sv -----
// Channel    Dir  Payload (low bit first)                  Handshake
// s_*        in   s_tdata: tick                            s_tvalid / s_tready
// m_*        out  m_tdata: swap_position; m_tlast: last    m_tvalid / m_tready
// cfg_*      in   cfg_wdata: perm_size                     cfg_we, no wait
//
// A tick of 1 occupies the unit through a start step, then a sweep over each element of the
// active size (perm_size clamped to 1..MAX_ELEMENTS) as the order ring passes the shared step
// unit, then a hand-over step. A schedule wrap goes from the start straight to the hand-over.
// A tick of 0 gives no result and leaves the unit ready.
// Reset restores perm_size 6 and the identity order; a perm_size write restarts the
// schedule. A stalled result holds in the output register; the next result then waits
// in the done state and the input stays not ready.
`include "adjacent_swap_permutation_guide_unit_assert.svh"

module adjacent_swap_permutation_guide_unit #(
	parameter int unsigned MAX_ELEMENTS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [aspg_pkg::TDATA_W-1:0]  s_tdata,   // [0] tick
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [aspg_pkg::TDATA_W-1:0]  m_tdata,   // [2:0] swap_position
	output logic                          m_tlast,   // last
	input  logic                          cfg_we,
	input  logic [aspg_pkg::SIZE_W-1:0]   cfg_wdata  // perm_size
);
	import aspg_pkg::*;

	localparam int unsigned EW = $clog2(MAX_ELEMENTS);
	localparam int unsigned NW = $clog2(MAX_ELEMENTS + 1);
	localparam int unsigned SW = (NW > SIZE_W) ? NW : SIZE_W;
	localparam int unsigned XW = (EW > POS_W) ? EW : POS_W;
	localparam int unsigned R2 = (MAX_ELEMENTS > 2) ? 2 : 0;

	// Clamp the size register to the supported element count.
	function automatic logic [NW-1:0] active_n(input logic [SIZE_W-1:0] size);
		logic [SW-1:0] x;
		x = SW'(size);
		if (x == '0) begin
			return NW'(1);
		end else if (x > SW'(MAX_ELEMENTS)) begin
			return NW'(MAX_ELEMENTS);
		end
		return NW'(x);
	endfunction

	logic [SIZE_W-1:0]  perm_size_q;
	logic [EW-1:0]      order_q [MAX_ELEMENTS];
	logic               dir_q [MAX_ELEMENTS];
	logic [EW-1:0]      mob_pos_q;
	logic [EW-1:0]      mob_elem_q;
	logic               mob_dir_q;
	logic               mob_valid_q;
	logic [EW-1:0]      low_q;
	logic [EW-1:0]      moved_q;
	logic [EW-1:0]      prev_q;
	logic [EW-1:0]      pos_q;
	logic [POS_W-1:0]   res_pos_q;
	logic               res_last_q;
	logic [POS_W-1:0]   out_pos_q;
	logic               out_last_q;
	logic               out_valid_q;

	logic [NW-1:0]      n;
	logic [NW-1:0]      restart_n;
	logic               move_ok;
	logic [EW-1:0]      low_next;
	logic [XW-1:0]      low_x;
	logic [EW-1:0]      proc_elem;
	logic               proc_dir;
	step_flag_t         flags;
	ctrl_status_t       status;
	ctrl_cmd_t          cmd;

	assign n = active_n(perm_size_q);
	assign restart_n = active_n(cfg_we ? cfg_wdata : perm_size_q);

	// The stored mobile element can move only when its neighbor lies inside the active range.
	assign move_ok = mob_valid_q &&
		(mob_dir_q ? ((NW'(mob_pos_q) + NW'(1)) < n) : (mob_pos_q != '0));
	assign low_next = mob_dir_q ? mob_pos_q : (mob_pos_q - EW'(1));
	assign low_x = XW'(low_q);

	assign status.accept = s_tvalid && s_tready;
	assign status.tick = s_tdata[0];
	assign status.move_ok = move_ok;
	assign status.sweep_end = ((NW'(pos_q) + NW'(1)) == n);
	assign status.out_free = !out_valid_q || m_tready;

	aspg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	aspg_step_unit #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_step (
		.pos        (pos_q),
		.n          (n),
		.low        (low_q),
		.moved_elem (moved_q),
		.tap0_elem  (order_q[0]),
		.tap0_dir   (dir_q[0]),
		.tap1_elem  (order_q[1]),
		.tap1_dir   (dir_q[1]),
		.tap2_elem  (order_q[R2]),
		.prev_elem  (prev_q),
		.mob_valid  (mob_valid_q),
		.mob_elem   (mob_elem_q),
		.proc_elem  (proc_elem),
		.proc_dir   (proc_dir),
		.flags      (flags)
	);

	// Size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			perm_size_q <= cfg_wdata;
		end
	end

	// Order ring: the active entries rotate past the step unit once per sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_ELEMENTS; k++) begin
				order_q[k] <= EW'(k);
				dir_q[k] <= 1'b0;
			end
		end else if (cfg_we || cmd.wrap) begin
			for (int k = 0; k < MAX_ELEMENTS; k++) begin
				order_q[k] <= EW'(k);
				dir_q[k] <= 1'b0;
			end
		end else if (cmd.step) begin
			for (int k = 0; k < MAX_ELEMENTS - 1; k++) begin
				if ((NW'(k) + NW'(1)) == n) begin
					order_q[k] <= proc_elem;
					dir_q[k] <= proc_dir;
				end else if ((NW'(k) + NW'(1)) < n) begin
					if ((k == 0) && flags.swap_now) begin
						order_q[k] <= order_q[0];
						dir_q[k] <= dir_q[0];
					end else begin
						order_q[k] <= order_q[k + 1];
						dir_q[k] <= dir_q[k + 1];
					end
				end
			end
			if (NW'(MAX_ELEMENTS) == n) begin
				order_q[MAX_ELEMENTS - 1] <= proc_elem;
				dir_q[MAX_ELEMENTS - 1] <= proc_dir;
			end
		end
	end

	// Largest mobile element, rebuilt during each sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mob_pos_q <= EW'(active_n(SIZE_RESET) - NW'(1));
			mob_elem_q <= EW'(active_n(SIZE_RESET) - NW'(1));
			mob_dir_q <= 1'b0;
			mob_valid_q <= (active_n(SIZE_RESET) > NW'(1));
		end else if (cfg_we || cmd.wrap) begin
			mob_pos_q <= EW'(restart_n - NW'(1));
			mob_elem_q <= EW'(restart_n - NW'(1));
			mob_dir_q <= 1'b0;
			mob_valid_q <= (restart_n > NW'(1));
		end else if (cmd.start) begin
			mob_valid_q <= 1'b0;
		end else if (cmd.step && flags.better) begin
			mob_pos_q <= pos_q;
			mob_elem_q <= proc_elem;
			mob_dir_q <= proc_dir;
			mob_valid_q <= 1'b1;
		end
	end

	// Sweep position counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.start) begin
			pos_q <= '0;
		end else if (cmd.step) begin
			pos_q <= pos_q + EW'(1);
		end
	end

	// Per-sweep operands and the left neighbor of the next position.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			low_q <= low_next;
			moved_q <= mob_elem_q;
		end
		if (cmd.step) begin
			prev_q <= proc_elem;
		end
	end

	// Pending result of the current transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_last_q <= 1'b0;
		end else if (cmd.start) begin
			res_last_q <= 1'b0;
		end else if (cmd.wrap) begin
			res_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wrap) begin
			res_pos_q <= '0;
		end else if (cmd.step && status.sweep_end) begin
			res_pos_q <= low_x[POS_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_pos_q <= res_pos_q;
			out_last_q <= res_last_q;
		end
	end

	assign s_tready = cmd.ready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = {(TDATA_W - POS_W)'(0), out_pos_q};
	assign m_tlast = out_last_q;

	`ASPG_ASSERT_SAME(a_sweep_in_range, cmd.step, (NW'(pos_q) < n),
		"sweep position ran past the active size")
	`ASPG_ASSERT_SAME(a_last_at_zero, (m_tvalid && m_tlast), (m_tdata[POS_W-1:0] == '0),
		"final schedule entry must report position zero")
	`ASPG_ASSERT_NEXT(a_tick_blocks, (s_tvalid && s_tready && s_tdata[0]), !s_tready,
		"a tick must occupy the unit for at least one more cycle")
	`ASPG_ASSERT_SAME(a_mobile_inside, (s_tready && mob_valid_q), (NW'(mob_pos_q) < n),
		"stored mobile position lies outside the active size")
	`ASPG_ASSERT_SAME(a_load_when_free, cmd.load_out, (!out_valid_q || m_tready),
		"result loaded over an untaken output")

endmodule

// ----- tb/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import aspg_pkg::*;

	localparam int unsigned MAX_ELEMENTS = 8;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE_CYCLES = 24;
	localparam int unsigned HOLD_AT_RESULT = 150;
	localparam int unsigned HOLD_CYCLES = 300;

	typedef struct {
		logic [POS_W-1:0] position;
		logic             wrap;
	} guide_entry_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata = '0;      // [0] tick
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;           // [2:0] swap_position
	logic                m_tlast;           // last
	logic                cfg_we = 1'b0;
	logic [SIZE_W-1:0]   cfg_wdata = '0;    // perm_size

	// Shadow copy of the schedule state.
	logic [SIZE_W-1:0]   size_reg;
	logic [2:0]          elem_at [MAX_ELEMENTS];
	logic                faces_right [MAX_ELEMENTS];
	int                  mobile_at;
	logic                mobile_ok;

	logic                pending_ticks [$];
	guide_entry_t        guide_expected [$];
	int unsigned         cycle_cnt = 0;
	int unsigned         results_seen = 0;
	int unsigned         hold_left = 0;
	int unsigned         mismatches = 0;
	logic                calm;

	adjacent_swap_permutation_guide_unit #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Inside this window neither side inserts random idle cycles.
	assign calm = (cycle_cnt >= 4000) && (cycle_cnt < 7000);

	// Sizes outside 1..MAX_ELEMENTS are clamped.
	function automatic int active_size();
		int n;
		n = int'(size_reg);
		if (n < 1) begin
			n = 1;
		end
		if (n > MAX_ELEMENTS) begin
			n = MAX_ELEMENTS;
		end
		return n;
	endfunction

	// Back to the identity order with every element facing left.
	function automatic void restart_order();
		int n;
		n = active_size();
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			elem_at[i] = i[2:0];
			faces_right[i] = 1'b0;
		end
		mobile_ok = (n > 1);
		mobile_at = (n > 1) ? n - 1 : 0;
	endfunction

	// One step of the adjacent-swap schedule; returns the guide entry.
	function automatic guide_entry_t advance_schedule();
		guide_entry_t entry;
		int n, p, q, best;
		logic [2:0] moved, held;
		logic moved_dir, mob, found;
		n = active_size();
		p = mobile_at;
		q = (mobile_ok && p < n) ? (faces_right[p] ? p + 1 : p - 1) : n;
		entry.position = '0;
		entry.wrap = 1'b1;
		if (!mobile_ok || p >= n || q < 0 || q >= n) begin
			restart_order();
			return entry;
		end
		moved = elem_at[p];
		moved_dir = faces_right[p];
		held = elem_at[q];
		elem_at[q] = moved;
		elem_at[p] = held;
		faces_right[p] = faces_right[q];
		faces_right[q] = moved_dir;
		entry.position = (p < q) ? p[POS_W-1:0] : q[POS_W-1:0];
		entry.wrap = 1'b0;
		// Every element larger than the moved one turns around.
		for (int i = 0; i < n; i++) begin
			if (elem_at[i] > moved) begin
				faces_right[i] = ~faces_right[i];
			end
		end
		// Find the largest element that can still move.
		found = 1'b0;
		best = 0;
		for (int i = 0; i < n; i++) begin
			mob = (!faces_right[i] && i != 0 && elem_at[i] > elem_at[i - 1]) ||
				(faces_right[i] && i + 1 < n && elem_at[i] > elem_at[i + 1]);
			if (mob && (!found || elem_at[i] > elem_at[best])) begin
				best = i;
				found = 1'b1;
			end
		end
		mobile_at = best;
		mobile_ok = found;
		return entry;
	endfunction

	function automatic void flag_error(string msg);
		if (mismatches < 10) begin
			$display("%0t: %s", $realtime, msg);
		end
		mismatches++;
	endfunction

	// Queue the given number of ticks, with some zero ticks mixed in.
	function automatic void queue_ticks(int count, int zero_pct);
		int made;
		made = 0;
		while (made < count) begin
			if ($urandom_range(99) < zero_pct) begin
				pending_ticks.push_back(1'b0);
			end else begin
				pending_ticks.push_back(1'b1);
				made++;
			end
		end
	endfunction

	// Block until the stream is drained and the unit has finished its last sweep.
	task automatic wait_idle();
		while (pending_ticks.size() != 0 || s_tvalid || guide_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input logic [SIZE_W-1:0] value);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_reg = value;
		restart_order();
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Input driver: each accepted tick of 1 is predicted at its acceptance edge.
	always @(posedge clk) begin : send_ticks
		logic busy;
		busy = s_tvalid;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				busy = 1'b0;
				if (s_tdata[0]) begin
					guide_expected.push_back(advance_schedule());
				end
			end
			if (!busy) begin
				if (pending_ticks.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
					s_tdata <= {{(TDATA_W-1){1'b0}}, pending_ticks.pop_front()};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor and receiver, with one long hold-off to back the unit up.
	always @(posedge clk) begin : take_results
		guide_entry_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (guide_expected.size() == 0) begin
					flag_error($sformatf("unexpected result tdata=%0h tlast=%0b",
						m_tdata, m_tlast));
				end else begin
					want = guide_expected.pop_front();
					if (m_tdata !== {{(TDATA_W-POS_W){1'b0}}, want.position}) begin
						flag_error($sformatf("swap_position expected %0d got tdata=%0h",
							want.position, m_tdata));
					end
					if (m_tlast !== want.wrap) begin
						flag_error($sformatf("last expected %0b got %0b",
							want.wrap, m_tlast));
					end
				end
				results_seen++;
				if (results_seen == HOLD_AT_RESULT) begin
					hold_left = HOLD_CYCLES;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 33);
			end
		end
	end

	// Stimulus sequence: directed cases first, then random phases at several sizes.
	initial begin
		logic [SIZE_W-1:0] phase_size [12];
		int phase_ticks [12];
		phase_size = '{4'd4, 4'd5, 4'd3, 4'd8, 4'd2, 4'd1, 4'd6, 4'd7, 4'd0, 4'd11, 4'd5, 4'd4};
		phase_ticks = '{60, 110, 35, 80, 18, 10, 70, 55, 10, 27, 120, 55};
		size_reg = SIZE_RESET;
		restart_order();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset size, with a zero tick in between.
		pending_ticks.push_back(1'b1);
		pending_ticks.push_back(1'b0);
		pending_ticks.push_back(1'b1);
		// Size one wraps on every tick; size zero acts as one.
		write_size(4'd1);
		repeat (3) pending_ticks.push_back(1'b1);
		write_size(4'd0);
		repeat (2) pending_ticks.push_back(1'b1);
		// Size two: one swap, then the wrap, then again.
		write_size(4'd2);
		repeat (4) pending_ticks.push_back(1'b1);
		// Size three through a whole schedule and into the next.
		write_size(4'd3);
		repeat (3) pending_ticks.push_back(1'b1);
		pending_ticks.push_back(1'b0);
		repeat (4) pending_ticks.push_back(1'b1);
		// Largest encoding clamps to the maximum size.
		write_size(4'd15);
		repeat (3) pending_ticks.push_back(1'b1);

		// Random phases; writes land mid-schedule and restart it.
		for (int ph = 0; ph < 12; ph++) begin
			write_size(phase_size[ph]);
			queue_ticks(phase_ticks[ph], 10);
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- adjacent_swap_permutation_guide_unit.f -----
+incdir+hw/rtl
hw/rtl/aspg_pkg.sv
hw/rtl/aspg_step_unit.sv
hw/rtl/aspg_ctrl.sv
hw/rtl/adjacent_swap_permutation_guide_unit.sv
tb/tb.sv
